[design/asa_pkg.sv]
// Shared constants for the activity segment accumulator.
package asa_pkg;

    // Width of the activity code carried by every track point
    localparam int ACT_BITS = 4;

    // Number of distinct activity codes
    localparam int ACT_CODES = 2 ** ACT_BITS;

    // Value lanes kept per activity: distance, ascent, descent, seconds, moving seconds
    localparam int NUM_SUMS = 5;

    // Lane positions inside a packed row of sums
    localparam int LANE_DISTANCE = 0;
    localparam int LANE_ASCENT   = 1;
    localparam int LANE_DESCENT  = 2;
    localparam int LANE_SECONDS  = 3;
    localparam int LANE_MOVING   = 4;

endpackage

[design/asa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module asa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/activity_segment_accumulator.sv]
// Activity segment accumulator: run tracker, accumulator RAM update stage and output register.
// A range word passes from the update stage to the output register: the update stage loads
// when its point is accepted, and the output register loads from it once the output is free.
// Throughput: one point per cycle while the output is not stalled; a point that closes two
// ranges holds the input for its second update: one accumulator read-modify-write per cycle.
// Reset clears the open run and the row valid bits, so the table reads as all zero at once;
// there is no clearing pass, and a track start clears the valid bits the same way.
module activity_segment_accumulator #(
    parameter int NUM_ACTIVITIES = 16,
    parameter int VALUE_BITS     = 32,
    parameter int INDEX_BITS     = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [asa_pkg::ACT_BITS-1:0] activity,
    input  logic [VALUE_BITS-1:0]        cum_distance,
    input  logic [VALUE_BITS-1:0]        cum_ascent,
    input  logic [VALUE_BITS-1:0]        cum_descent,
    input  logic [VALUE_BITS-1:0]        cum_seconds,
    input  logic [VALUE_BITS-1:0]        cum_moving_seconds,
    input  logic [INDEX_BITS-1:0]        point_index,
    input  logic                         track_start,
    input  logic                         track_end,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [asa_pkg::ACT_BITS-1:0] range_activity,
    output logic [INDEX_BITS-1:0]        range_begin,
    output logic [INDEX_BITS-1:0]        range_end,
    output logic [VALUE_BITS-1:0]        total_distance,
    output logic [VALUE_BITS-1:0]        total_ascent,
    output logic [VALUE_BITS-1:0]        total_descent,
    output logic [VALUE_BITS-1:0]        total_seconds,
    output logic [VALUE_BITS-1:0]        total_moving_seconds,
    output logic                         last_of_run
);

    import asa_pkg::*;

    localparam int ROW_BITS = $clog2(NUM_ACTIVITIES);
    localparam int SUM_BITS = NUM_SUMS * VALUE_BITS;

    // One table update: which row, what to add, and the range it reports
    typedef struct packed {
        logic                  clear;
        logic                  last;
        logic [ROW_BITS-1:0]   row;
        logic [ACT_BITS-1:0]   act;
        logic [INDEX_BITS-1:0] idx_first;
        logic [INDEX_BITS-1:0] idx_last;
        logic [SUM_BITS-1:0]   delta;
    } op_t;

    // Activity code to table row (code modulo the table depth)
    logic [ROW_BITS-1:0] row_lut [ACT_CODES];

    for (genvar g = 0; g < ACT_CODES; g++)
    begin : g_row_lut
        assign row_lut[g] = ROW_BITS'(g % NUM_ACTIVITIES);
    end

    // Run tracker state
    logic                  run_open_reg;
    logic                  run_open_next;
    logic [ACT_BITS-1:0]   run_act_reg;
    logic [ACT_BITS-1:0]   run_act_next;
    logic [INDEX_BITS-1:0] start_idx_reg;
    logic [INDEX_BITS-1:0] start_idx_next;
    logic [SUM_BITS-1:0]   start_val_reg;
    logic [SUM_BITS-1:0]   start_val_next;
    logic                  clear_pend_reg;
    logic                  clear_pend_next;

    // Second update of a point that closes two ranges
    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    op_t                   hold_op_reg;
    op_t                   hold_op_next;

    // Update stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    op_t                   s1_op_reg;
    op_t                   s1_op_next;

    // Row valid bits and write forwarding
    logic [NUM_ACTIVITIES-1:0] row_valid_reg;
    logic [NUM_ACTIVITIES-1:0] row_valid_next;
    logic                      fwd_valid_reg;
    logic                      fwd_valid_next;
    logic [ROW_BITS-1:0]       fwd_row_reg;
    logic [ROW_BITS-1:0]       fwd_row_next;
    logic [SUM_BITS-1:0]       fwd_data_reg;
    logic [SUM_BITS-1:0]       fwd_data_next;

    // Output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    op_t                   out_op_reg;
    op_t                   out_op_next;
    logic [SUM_BITS-1:0]   out_sum_reg;
    logic [SUM_BITS-1:0]   out_sum_next;

    // Front-end decode of the incoming point
    logic                  open_eff;
    logic                  chg;
    logic                  opening;
    logic [ACT_BITS-1:0]   base_act;
    logic [INDEX_BITS-1:0] base_idx;
    logic [SUM_BITS-1:0]   base_val;
    logic [SUM_BITS-1:0]   pt_val;
    logic [SUM_BITS-1:0]   delta_a;
    logic [SUM_BITS-1:0]   delta_b;
    logic                  clear_in;
    op_t                   op_a;
    op_t                   op_b;
    op_t                   first_op;
    logic                  any_op;
    logic                  two_ops;

    // Handshake and stage control
    logic                  out_free;
    logic                  s1_adv;
    logic                  s1_free;
    logic                  in_acc;
    logic                  s1_load;
    op_t                   s1_op_in;

    // Update arithmetic
    logic [SUM_BITS-1:0]   ram_rd_data;
    logic                  fwd_hit;
    logic [SUM_BITS-1:0]   old_sum;
    logic [SUM_BITS-1:0]   new_sum;

    asa_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (NUM_ACTIVITIES)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_op_reg.row),
        .wr_data (new_sum),
        .rd_en   (s1_load),
        .rd_addr (s1_op_in.row),
        .rd_data (ram_rd_data)
    );

    // Pack the point values into lanes
    assign pt_val = {cum_moving_seconds, cum_seconds, cum_descent, cum_ascent, cum_distance};

    // Decide which ranges this point closes
    always_comb
    begin
        open_eff = run_open_reg & ~track_start;
        chg      = open_eff & (activity != run_act_reg);
        opening  = ~open_eff | chg;
        base_act = opening ? activity : run_act_reg;
        base_idx = opening ? point_index : start_idx_reg;
        base_val = opening ? pt_val : start_val_reg;
        clear_in = track_start | clear_pend_reg;
        any_op   = chg | track_end;
        two_ops  = chg & track_end;

        for (int i = 0; i < NUM_SUMS; i++)
        begin
            delta_a[i*VALUE_BITS +: VALUE_BITS] = pt_val[i*VALUE_BITS +: VALUE_BITS]
                                                - start_val_reg[i*VALUE_BITS +: VALUE_BITS];
            delta_b[i*VALUE_BITS +: VALUE_BITS] = pt_val[i*VALUE_BITS +: VALUE_BITS]
                                                - base_val[i*VALUE_BITS +: VALUE_BITS];
        end

        // Close of the old run at an activity change
        op_a.clear     = clear_in;
        op_a.last      = ~track_end;
        op_a.row       = row_lut[run_act_reg];
        op_a.act       = run_act_reg;
        op_a.idx_first = start_idx_reg;
        op_a.idx_last  = point_index;
        op_a.delta     = delta_a;

        // Flush at track end
        op_b.clear     = chg ? 1'b0 : clear_in;
        op_b.last      = 1'b1;
        op_b.row       = row_lut[base_act];
        op_b.act       = base_act;
        op_b.idx_first = base_idx;
        op_b.idx_last  = point_index;
        op_b.delta     = delta_b;

        first_op = chg ? op_a : op_b;
    end

    // Stage control
    always_comb
    begin
        out_free = ~out_valid_reg | out_ready;
        s1_adv   = s1_valid_reg & out_free;
        s1_free  = ~s1_valid_reg | s1_adv;
        in_ready = ~hold_valid_reg & s1_free;
        in_acc   = in_valid & in_ready;
        s1_load  = hold_valid_reg ? s1_free : (in_acc & any_op);
        s1_op_in = hold_valid_reg ? hold_op_reg : first_op;
    end

    // Next state of the run tracker and the held second update
    always_comb
    begin
        run_open_next   = run_open_reg;
        run_act_next    = run_act_reg;
        start_idx_next  = start_idx_reg;
        start_val_next  = start_val_reg;
        clear_pend_next = clear_pend_reg;
        hold_valid_next = hold_valid_reg;
        hold_op_next    = hold_op_reg;

        if (hold_valid_reg && s1_free)
        begin
            hold_valid_next = 1'b0;
        end

        if (in_acc)
        begin
            run_open_next   = ~track_end;
            run_act_next    = base_act;
            start_idx_next  = base_idx;
            start_val_next  = base_val;
            clear_pend_next = clear_in & ~any_op;
            if (two_ops)
            begin
                hold_valid_next = 1'b1;
                hold_op_next    = op_b;
            end
        end
    end

    // Read-modify-write of the accumulator row
    always_comb
    begin
        fwd_hit = fwd_valid_reg && (fwd_row_reg == s1_op_reg.row);
        if (s1_op_reg.clear)
        begin
            old_sum = '0;
        end
        else if (fwd_hit)
        begin
            old_sum = fwd_data_reg;
        end
        else if (row_valid_reg[s1_op_reg.row])
        begin
            old_sum = ram_rd_data;
        end
        else
        begin
            old_sum = '0;
        end

        for (int i = 0; i < NUM_SUMS; i++)
        begin
            new_sum[i*VALUE_BITS +: VALUE_BITS] = old_sum[i*VALUE_BITS +: VALUE_BITS]
                                                + s1_op_reg.delta[i*VALUE_BITS +: VALUE_BITS];
        end
    end

    // Next state of the update stage, valid bits, forwarding and output
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_op_next     = s1_op_reg;
        row_valid_next = row_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_row_next   = fwd_row_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg;
        out_op_next    = out_op_reg;
        out_sum_next   = out_sum_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            if (s1_op_reg.clear)
            begin
                row_valid_next = '0;
            end
            row_valid_next[s1_op_reg.row] = 1'b1;
            fwd_valid_next = 1'b1;
            fwd_row_next   = s1_op_reg.row;
            fwd_data_next  = new_sum;
            out_valid_next = 1'b1;
            out_op_next    = s1_op_reg;
            out_sum_next   = new_sum;
        end

        if (s1_load)
        begin
            s1_valid_next = 1'b1;
            s1_op_next    = s1_op_in;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg   <= 1'b0;
            run_act_reg    <= '0;
            start_idx_reg  <= '0;
            start_val_reg  <= '0;
            clear_pend_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            row_valid_reg  <= '0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            run_open_reg   <= run_open_next;
            run_act_reg    <= run_act_next;
            start_idx_reg  <= start_idx_next;
            start_val_reg  <= start_val_next;
            clear_pend_reg <= clear_pend_next;
            hold_valid_reg <= hold_valid_next;
            s1_valid_reg   <= s1_valid_next;
            row_valid_reg  <= row_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hold_op_reg  <= hold_op_next;
        s1_op_reg    <= s1_op_next;
        fwd_row_reg  <= fwd_row_next;
        fwd_data_reg <= fwd_data_next;
        out_op_reg   <= out_op_next;
        out_sum_reg  <= out_sum_next;
    end

    // Drive the output word
    assign out_valid            = out_valid_reg;
    assign range_activity       = out_op_reg.act;
    assign range_begin          = out_op_reg.idx_first;
    assign range_end            = out_op_reg.idx_last;
    assign last_of_run          = out_op_reg.last;
    assign total_distance       = out_sum_reg[LANE_DISTANCE*VALUE_BITS +: VALUE_BITS];
    assign total_ascent         = out_sum_reg[LANE_ASCENT*VALUE_BITS +: VALUE_BITS];
    assign total_descent        = out_sum_reg[LANE_DESCENT*VALUE_BITS +: VALUE_BITS];
    assign total_seconds        = out_sum_reg[LANE_SECONDS*VALUE_BITS +: VALUE_BITS];
    assign total_moving_seconds = out_sum_reg[LANE_MOVING*VALUE_BITS +: VALUE_BITS];

    // A held second update always sits behind its first one in the update stage
    a_hold_behind_s1: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> s1_valid_reg)
        else $error("second update held with update stage empty");

    // The first word of a two-range point is followed by its flush in the update stage
    a_first_word_has_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_op_reg.last) |-> s1_valid_reg)
        else $error("non-final word without its flush behind it");

    // Table row stays inside the table
    a_row_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (32'(s1_op_reg.row) < NUM_ACTIVITIES))
        else $error("accumulator row out of range");

endmodule
